/* sv/dilp_pkg.sv */
// Shared types and constants of the decimal integer line parser.
`timescale 1ns / 1ps
package dilp_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned WORD_W   = 8;
  localparam logic [WORD_W-1:0] WORD_SAT = 8'd255;
  localparam int unsigned NUM_W    = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned JOB_CNT_W = 7;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_EOI  = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    ST_VALUE = 2'd0,
    ST_EOD   = 2'd1,
    ST_DROP  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TS_NONE   = 2'd0,
    TS_SIGN   = 2'd1,
    TS_DIGITS = 2'd2
  } tok_state_e;

  typedef enum logic [1:0] {
    JOB_VALUES = 2'd0,
    JOB_EOD    = 2'd1,
    JOB_DROP   = 2'd2
  } job_e;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_VALUE  = 2'd1,
    BK_STATUS = 2'd2
  } back_state_e;

  typedef struct packed {
    job_e                 kind;
    logic                 bank;
    logic [JOB_CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

/* sv/dilp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dilp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/dilp_front.sv */
// Front end: takes characters, counts words, tokenizes values, queues line jobs.
`timescale 1ns / 1ps
module dilp_front
  import dilp_pkg::*;
#(
  parameter int unsigned MAX_WORDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  char_i,
  input  logic [1:0]  kind_i,
  input  logic        q_full_i,
  output logic        push_o,
  output job_t        job_o,
  input  rel_t        rel_i,
  output logic        we_o,
  output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1):0] waddr_o,
  output logic [NUM_W-1:0] wdata_o
);

  localparam int unsigned IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned VP_W  = $clog2(MAX_WORDS + 1);
  localparam logic [VP_W-1:0]   VP_MAX = VP_W'(MAX_WORDS);
  localparam logic [WORD_W-1:0] WT_MAX = WORD_W'(MAX_WORDS);

  logic [NUM_W-1:0]  acc_q, acc_d;
  logic              neg_q, neg_d;
  tok_state_e        ts_q, ts_d;
  logic [WORD_W-1:0] wt_q, wt_d;
  logic              blank_q, blank_d;
  logic [VP_W-1:0]   vp_q, vp_d;
  logic              fail_q, fail_d;
  logic              start_q, start_d;
  logic              comment_q, comment_d;
  logic              bank_q, bank_d;
  logic [1:0]        busy_q, busy_d;

  logic              take;
  logic              digit;
  logic [3:0]        dval;
  logic [NUM_W-1:0]  value;
  logic [NUM_W-1:0]  acc_x10;

  assign ready_o = !q_full_i && !busy_q[bank_q];
  assign take    = valid_i && ready_o;
  assign digit   = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign dval    = char_i[3:0];
  assign value   = neg_q ? (NUM_W'(0) - acc_q) : acc_q;
  assign acc_x10 = {acc_q[NUM_W-4:0], 3'b000} + {acc_q[NUM_W-2:0], 1'b0};
  assign waddr_o = {bank_q, vp_q[IDX_W-1:0]};
  assign wdata_o = value;

  always_comb begin
    logic       comm;
    logic       go;
    logic [VP_W-1:0] vp_fin;
    tok_state_e ts_loc;
    acc_d     = acc_q;
    neg_d     = neg_q;
    ts_d      = ts_q;
    wt_d      = wt_q;
    blank_d   = blank_q;
    vp_d      = vp_q;
    fail_d    = fail_q;
    start_d   = start_q;
    comment_d = comment_q;
    bank_d    = bank_q;
    busy_d    = busy_q;
    we_o      = 1'b0;
    push_o    = 1'b0;
    job_o     = '{kind: JOB_VALUES, bank: bank_q, count: JOB_CNT_W'(wt_q)};
    comm      = 1'b0;
    go        = 1'b0;
    vp_fin    = vp_q;
    ts_loc    = ts_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (take) begin
      case (item_kind_e'(kind_i))
        KIND_CHAR: begin
          start_d   = 1'b0;
          comm      = comment_q || (start_q && (char_i == CH_HASH));
          comment_d = comm;
          if (!comm) begin
            if (char_i == CH_SPACE) begin
              blank_d = 1'b1;
            end else if (blank_q) begin
              if (wt_q != WORD_SAT) begin
                wt_d = wt_q + WORD_W'(1);
              end
              blank_d = 1'b0;
            end
            if (!fail_q && (vp_q < VP_MAX)) begin
              go = 1'b1;
              if (ts_q == TS_DIGITS) begin
                if (digit) begin
                  acc_d = acc_x10 + NUM_W'(dval);
                  go    = 1'b0;
                end else begin
                  we_o   = 1'b1;
                  vp_d   = vp_q + VP_W'(1);
                  acc_d  = '0;
                  neg_d  = 1'b0;
                  ts_d   = TS_NONE;
                  ts_loc = TS_NONE;
                  if ((vp_q + VP_W'(1)) >= VP_MAX) begin
                    go = 1'b0;
                  end
                end
              end
              if (go && (char_i != CH_SPACE)) begin
                if (digit) begin
                  ts_d  = TS_DIGITS;
                  acc_d = NUM_W'(dval);
                end else if ((ts_loc != TS_SIGN) && (char_i == CH_MINUS)) begin
                  ts_d  = TS_SIGN;
                  neg_d = 1'b1;
                end else if ((ts_loc != TS_SIGN) && (char_i == CH_PLUS)) begin
                  ts_d  = TS_SIGN;
                  neg_d = 1'b0;
                end else begin
                  fail_d = 1'b1;
                end
              end
            end
          end
        end
        KIND_EOL: begin
          if (!comment_q && (wt_q != '0)) begin
            if (wt_q > WT_MAX) begin
              push_o     = 1'b1;
              job_o.kind = JOB_DROP;
            end else begin
              if (!fail_q && (ts_q == TS_DIGITS) && (vp_q < VP_MAX)) begin
                we_o   = 1'b1;
                vp_fin = vp_q + VP_W'(1);
              end
              if (wt_q <= WORD_W'(vp_fin)) begin
                push_o = 1'b1;
                busy_d[bank_q] = 1'b1;
                bank_d = !bank_q;
              end
            end
          end
          acc_d = '0; neg_d = 1'b0; ts_d = TS_NONE; wt_d = '0; blank_d = 1'b1;
          vp_d = '0; fail_d = 1'b0; start_d = 1'b1; comment_d = 1'b0;
        end
        KIND_EOI: begin
          push_o     = 1'b1;
          job_o.kind = JOB_EOD;
          acc_d = '0; neg_d = 1'b0; ts_d = TS_NONE; wt_d = '0; blank_d = 1'b1;
          vp_d = '0; fail_d = 1'b0; start_d = 1'b1; comment_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      neg_q     <= 1'b0;
      ts_q      <= TS_NONE;
      wt_q      <= '0;
      blank_q   <= 1'b1;
      vp_q      <= '0;
      fail_q    <= 1'b0;
      start_q   <= 1'b1;
      comment_q <= 1'b0;
      bank_q    <= 1'b0;
      busy_q    <= '0;
    end else begin
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      ts_q      <= ts_d;
      wt_q      <= wt_d;
      blank_q   <= blank_d;
      vp_q      <= vp_d;
      fail_q    <= fail_d;
      start_q   <= start_d;
      comment_q <= comment_d;
      bank_q    <= bank_d;
      busy_q    <= busy_d;
    end
  end

endmodule

/* sv/dilp_queue.sv */
// Two-entry job queue between front and back end.
`timescale 1ns / 1ps
module dilp_queue
  import dilp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic full_o,
  output logic empty_o
);

  job_t       ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* sv/dilp_back.sv */
// Back end: drains queued jobs, reads line values and drives the result stream.
`timescale 1ns / 1ps
module dilp_back
  import dilp_pkg::*;
#(
  parameter int unsigned MAX_WORDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output rel_t        rel_o,
  output logic        re_o,
  output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1):0] raddr_o,
  input  logic [NUM_W-1:0] rdata_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [NUM_W-1:0] number_o,
  output logic [POS_W-1:0] position_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int unsigned IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  back_state_e          state_q, state_d;
  logic                 bank_q, bank_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [JOB_CNT_W-1:0] cnt_q, cnt_d;
  status_e              status_q, status_d;
  logic                 at_last;

  assign at_last = ((JOB_CNT_W'(idx_q) + JOB_CNT_W'(1)) == cnt_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = (head_i.kind == JOB_VALUES) ? BK_VALUE : BK_STATUS;
        end
      end
      BK_VALUE: begin
        if (ready_i && at_last) begin
          state_d = BK_IDLE;
        end
      end
      BK_STATUS: begin
        if (ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    bank_d     = bank_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    pop_o      = 1'b0;
    rel_o      = '{valid: 1'b0, bank: bank_q};
    re_o       = 1'b0;
    raddr_o    = {bank_q, idx_q};
    valid_o    = 1'b0;
    number_o   = '0;
    position_o = '0;
    status_o   = ST_VALUE;
    last_o     = 1'b1;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.kind == JOB_VALUES) begin
            bank_d  = head_i.bank;
            idx_d   = '0;
            cnt_d   = head_i.count;
            re_o    = 1'b1;
            raddr_o = {head_i.bank, IDX_W'(0)};
          end else begin
            status_d = (head_i.kind == JOB_EOD) ? ST_EOD : ST_DROP;
          end
        end
      end
      BK_VALUE: begin
        valid_o    = 1'b1;
        number_o   = rdata_i;
        position_o = POS_W'(idx_q);
        last_o     = at_last;
        if (ready_i) begin
          if (at_last) begin
            rel_o.valid = 1'b1;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            re_o    = 1'b1;
            raddr_o = {bank_q, idx_q + IDX_W'(1)};
          end
        end
      end
      BK_STATUS: begin
        valid_o  = 1'b1;
        status_o = status_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q   <= bank_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
  end

endmodule

/* sv/decimal_integer_line_parser.sv */
// Top level of the decimal integer line parser.
//
//   channel  | dir | tdata                         | tuser        | tlast
//   s_axis   | in  | [7:0] char_code               | [1:0] kind   | -
//   m_axis   | out | [31:0] number, [36:32] pos    | [1:0] status | last_of_run
//
// Input takes one item per cycle while the job queue has room and the value
// bank being filled is not still being drained by the back end.
// Each job is popped in the idle state; a line's values then leave one per cycle
// while m_axis_tready is high, from the two-bank value RAM (registered read);
// a status job gives a single result.
// Up to two line jobs wait in the queue.
// Reset is asynchronous, active low; the value RAM needs no clearing.
`timescale 1ns / 1ps
module decimal_integer_line_parser
  import dilp_pkg::*;
#(
  parameter int unsigned MAX_WORDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [1:0]  s_axis_tuser,   // [1:0] item_kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] number, [36:32] position, zero pad
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);

  localparam int unsigned IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned RAM_DEPTH = 2 << IDX_W;

  logic             q_full, q_empty, push, pop;
  job_t             job_in, job_head;
  rel_t             rel;
  logic             we, re;
  logic [IDX_W:0]   waddr, raddr;
  logic [NUM_W-1:0] wdata, rdata;
  logic [NUM_W-1:0] number;
  logic [POS_W-1:0] position;

  dilp_front #(.MAX_WORDS(MAX_WORDS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .char_i   (s_axis_tdata),
    .kind_i   (s_axis_tuser),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job_in),
    .rel_i    (rel),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata)
  );

  dilp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .head_o  (job_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  dilp_ram #(.WIDTH(NUM_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dilp_back #(.MAX_WORDS(MAX_WORDS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (job_head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .rel_o      (rel),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .number_o   (number),
    .position_o (position),
    .status_o   (m_axis_tuser),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, position, number};

endmodule

/* tb/tb_decimal_integer_line_parser.sv */
// Self-checking testbench of the decimal integer line parser: item stream in, checked results out.
`timescale 1ns / 1ps
module tb_decimal_integer_line_parser;
  import dilp_pkg::*;

  localparam int unsigned MAX_WORDS = 32;
  localparam int RANDOM_ITEMS = 290;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] number;
    logic [4:0]  position;
    status_e     status;
    logic        last;
  } line_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_code
  logic [1:0]  s_axis_tuser;   // [1:0] item_kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] number, [36:32] position, zero pad
  logic [1:0]  m_axis_tuser;   // [1:0] status
  logic        m_axis_tlast;

  decimal_integer_line_parser #(
    .MAX_WORDS(MAX_WORDS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // parser state mirror
  logic [31:0] line_values[MAX_WORDS];
  logic [31:0] acc;
  logic        neg;
  tok_state_e  tok;
  logic [7:0]  words;
  logic        blank;
  logic [7:0]  parsed;
  logic        failed;
  logic        line_start;
  logic        comment;

  line_result_t expected_values[$];
  logic [7:0]   line_chars[$];
  int           items_sent = 0;
  int           error_count = 0;
  int           burst_left = 0;
  int           ready_span = 0;
  int           ready_mode = 0;
  string        big_values[4] = '{"2147483647", "-2147483648", "4294967295", "99999999999"};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void restart_line();
    acc = '0;
    neg = 1'b0;
    tok = TS_NONE;
    words = '0;
    blank = 1'b1;
    parsed = '0;
    failed = 1'b0;
    line_start = 1'b1;
    comment = 1'b0;
  endfunction

  function automatic void close_value();
    logic [31:0] v;
    v = neg ? (32'd0 - acc) : acc;
    if (parsed < MAX_WORDS) begin
      line_values[parsed] = v;
      parsed++;
    end
    acc = '0;
    neg = 1'b0;
    tok = TS_NONE;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    logic        is_digit;
    logic [31:0] d;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = 32'(c) - 32'(CH_ZERO);
    if (failed || parsed >= MAX_WORDS) return;
    if (tok == TS_DIGITS) begin
      if (is_digit) begin
        acc = acc * 32'd10 + d;
        return;
      end
      close_value();
      if (parsed >= MAX_WORDS) return;
    end
    if (c == CH_SPACE) return;
    if (is_digit) begin
      tok = TS_DIGITS;
      acc = d;
    end else if (tok != TS_SIGN && c == CH_MINUS) begin
      tok = TS_SIGN;
      neg = 1'b1;
    end else if (tok != TS_SIGN && c == CH_PLUS) begin
      tok = TS_SIGN;
      neg = 1'b0;
    end else begin
      failed = 1'b1;
    end
  endfunction

  function automatic void add_expected(logic [31:0] num, logic [4:0] pos, status_e st,
                                       logic last);
    line_result_t r;
    r.number = num;
    r.position = pos;
    r.status = st;
    r.last = last;
    expected_values.push_back(r);
  endfunction

  function automatic void parse_item(logic [1:0] kind, logic [7:0] c);
    case (kind)
      KIND_CHAR: begin
        if (line_start) begin
          line_start = 1'b0;
          if (c == CH_HASH) comment = 1'b1;
        end
        if (!comment) begin
          if (c == CH_SPACE) begin
            blank = 1'b1;
          end else if (blank) begin
            if (words != WORD_SAT) words++;
            blank = 1'b0;
          end
          scan_char(c);
        end
      end
      KIND_EOL: begin
        if (!comment && words != 0) begin
          if (words > MAX_WORDS) begin
            add_expected('0, '0, ST_DROP, 1'b1);
          end else begin
            if (!failed && tok == TS_DIGITS) close_value();
            if (words <= parsed) begin
              for (int i = 0; i < words; i++) begin
                add_expected(line_values[i], 5'(i), ST_VALUE, (i + 1 == words));
              end
            end
          end
        end
        restart_line();
      end
      KIND_EOI: begin
        restart_line();
        add_expected('0, '0, ST_EOD, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_error(string msg);
    if (error_count < 10) $display("mismatch: %s", msg);
    error_count++;
  endfunction

  // sender: bursts with random gaps
  task automatic send_item(logic [1:0] kind, logic [7:0] ch);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tuser <= kind;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    parse_item(kind, ch);
    if (kind != KIND_UNUSED) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endtask

  task automatic add_spaces(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) line_chars.push_back(CH_SPACE);
  endtask

  task automatic add_number();
    int r;
    int ndig;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      add_text(big_values[$urandom_range(0, 3)]);
    end else begin
      if (r < 6) line_chars.push_back(CH_MINUS);
      else if (r < 9) line_chars.push_back(CH_PLUS);
      ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
      repeat (ndig) line_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic send_line(bit with_eol);
    for (int i = 0; i < line_chars.size(); i++) begin
      if ($urandom_range(0, 49) == 0) send_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
      send_item(KIND_CHAR, line_chars[i]);
    end
    line_chars.delete();
    if (with_eol) send_item(KIND_EOL, 8'($urandom_range(0, 255)));
  endtask

  task automatic build_numbers_line(int n);
    add_spaces(0, 2);
    for (int w = 0; w < n; w++) begin
      if (w > 0) add_spaces(1, 3);
      add_number();
      if ($urandom_range(0, 9) == 0) add_number();
    end
    add_spaces(0, 2);
  endtask

  // short single-digit words keep long lines cheap
  task automatic build_short_line(int n);
    for (int w = 0; w < n; w++) begin
      if (w > 0) line_chars.push_back(CH_SPACE);
      if ($urandom_range(0, 3) == 0) line_chars.push_back(CH_MINUS);
      line_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic build_noisy_line();
    int n;
    int len;
    n = $urandom_range(1, 5);
    for (int w = 0; w < n; w++) begin
      if (w > 0) add_spaces(1, 2);
      if ($urandom_range(0, 1) == 0) begin
        add_number();
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: line_chars.push_back(8'($urandom_range(0, 255)));
            1: line_chars.push_back(($urandom_range(0, 1) == 0) ? CH_MINUS :
                                    (($urandom_range(0, 1) == 0) ? CH_PLUS : CH_HASH));
            2: line_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            default: line_chars.push_back(8'($urandom_range(33, 126)));
          endcase
        end
      end
    end
  endtask

  task automatic test_directed();
    add_text("#9");
    send_line(1);
    send_line(1);
    add_text(" ");
    send_line(1);
    add_text("-7 12");
    send_line(1);
    add_text("+ 7 -");
    send_line(1);
    line_chars.push_back(8'hFF);
    add_text("1");
    send_line(1);
    add_text("3");
    line_chars.push_back(8'h00);
    send_line(1);
    send_item(KIND_UNUSED, 8'h5A);
    add_text("4");
    send_line(0);
    send_item(KIND_EOI, 8'hA5);
    send_item(KIND_EOI, 8'h00);
  endtask

  task automatic test_word_limit();
    build_short_line(MAX_WORDS);
    send_line(1);
    build_short_line(MAX_WORDS + $urandom_range(1, 6));
    send_line(1);
  endtask

  task automatic test_random();
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        build_numbers_line($urandom_range(1, 6));
        send_line(1);
      end else if (pick < 80) begin
        build_noisy_line();
        send_line(1);
      end else if (pick < 86) begin
        line_chars.push_back(CH_HASH);
        repeat ($urandom_range(0, 6)) line_chars.push_back(8'($urandom_range(0, 255)));
        send_line(1);
      end else if (pick < 90) begin
        add_spaces(0, 3);
        send_line(1);
      end else if (pick < 95) begin
        build_numbers_line($urandom_range(1, 3));
        send_line(0);
        send_item(KIND_EOI, 8'($urandom_range(0, 255)));
      end else if (pick < 98) begin
        send_item(KIND_EOI, 8'($urandom_range(0, 255)));
      end else begin
        send_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // receiver: ready pattern switches between free-running, random and sparse
  always @(posedge clk_i) begin
    if (ready_span == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_span <= $urandom_range(20, 200);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= (ready_span[2:0] == 3'd0);
    endcase
  end

  always @(negedge clk_i) begin
    line_result_t got;
    line_result_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.number = m_axis_tdata[31:0];
      got.position = m_axis_tdata[36:32];
      got.status = status_e'(m_axis_tuser);
      got.last = m_axis_tlast;
      if (expected_values.size() == 0) begin
        note_error($sformatf("unexpected item num=%0d pos=%0d st=%0d last=%0d",
                             $signed(got.number), got.position, got.status, got.last));
      end else begin
        exp = expected_values.pop_front();
        if (got != exp) begin
          note_error($sformatf({"exp num=%0d pos=%0d st=%0d last=%0d, ",
                                "got num=%0d pos=%0d st=%0d last=%0d"},
                               $signed(exp.number), exp.position, exp.status, exp.last,
                               $signed(got.number), got.position, got.status, got.last));
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    restart_line();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_word_limit();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
